FILE: rtl/core/ldfs_pkg.sv
package ldfs_pkg;

   // chain geometry
   localparam int MAX_CHIPS      = 16;
   localparam int CH_PER_CHIP    = 12;
   localparam int WORDS_PER_CHIP = 13;
   localparam int CHIP_W         = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;
   localparam int CHIP_CW        = CHIP_W + 1;
   localparam int WORD_W         = 4;
   localparam int STORE_DEPTH    = MAX_CHIPS * CH_PER_CHIP;
   localparam int STORE_AW       = $clog2(STORE_DEPTH);
   localparam int GREY_W         = 16;

   // word field widths
   localparam int CHIP_NUM_W = 5;
   localparam int CHAN_W     = 4;
   localparam int FRAC_W     = 17;
   localparam int CHAIN_W    = 5;
   localparam int WAIT_W     = 10;
   localparam int CSR_IDX_W  = 2;

   // scaler product width
   localparam int PROD_W     = FRAC_W + GREY_W;

   localparam logic [FRAC_W-1:0] FRAC_FULL = FRAC_W'(65536);
   localparam logic [WAIT_W-1:0] WAIT_RESET = WAIT_W'(300);
   localparam logic [WORD_W-1:0] LATCH_BITS = WORD_W'(8);

   typedef enum logic [1:0] {
      MODE_RAW     = 2'd0,
      MODE_SCALED  = 2'd1,
      MODE_REFRESH = 2'd2,
      MODE_TICK    = 2'd3
   } mode_type;

   localparam logic [CSR_IDX_W-1:0] CSR_COMMAND = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAIN   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAIT    = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic              accept;
      logic              store_we;
      logic              load_cmd;
      logic              load_mem;
      logic              shift_en;
      logic              pin_we;
      logic              pin_from_shift;
      logic              pin_data;
      logic              pin_clock;
      logic              busy;
      logic [CHIP_W-1:0] rd_chip;
      logic [WORD_W-1:0] rd_word;
   } ldfs_cmd_type;

   // channel sent in word slot w+1 of a chip
   function automatic logic [CHAN_W-1:0] send_order(input logic [WORD_W-1:0] w);
      logic [CHAN_W-1:0] ch;
      case (w)
         4'd0:    ch = 4'd9;
         4'd1:    ch = 4'd10;
         4'd2:    ch = 4'd11;
         4'd3:    ch = 4'd6;
         4'd4:    ch = 4'd7;
         4'd5:    ch = 4'd8;
         4'd6:    ch = 4'd3;
         4'd7:    ch = 4'd4;
         4'd8:    ch = 4'd5;
         4'd9:    ch = 4'd0;
         4'd10:   ch = 4'd1;
         4'd11:   ch = 4'd2;
         default: ch = 4'd0;
      endcase
      return ch;
   endfunction

   function automatic logic [GREY_W-1:0] grey_bias(input logic [1:0] sel);
      logic [GREY_W-1:0] b;
      case (sel)
         2'd0:    b = 16'h00ff;
         2'd1:    b = 16'h0fff;
         2'd2:    b = 16'h3fff;
         default: b = 16'hffff;
      endcase
      return b;
   endfunction

endpackage

FILE: rtl/core/ldfs_if.sv
interface ldfs_req_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      mode;
   logic [ldfs_pkg::CHIP_NUM_W-1:0] chip_number;
   logic [ldfs_pkg::CHAN_W-1:0]     channel;
   logic [ldfs_pkg::GREY_W-1:0]     raw_value;
   logic [ldfs_pkg::FRAC_W-1:0]     fraction;

   modport source (output valid, mode, chip_number, channel, raw_value, fraction,
                   input ready);
   modport sink   (input valid, mode, chip_number, channel, raw_value, fraction,
                   output ready);
endinterface

interface ldfs_rsp_if;
   logic valid;
   logic ready;
   logic data_pin;
   logic clock_pin;
   logic busy_res;

   modport source (output valid, data_pin, clock_pin, busy_res, input ready);
   modport sink   (input valid, data_pin, clock_pin, busy_res, output ready);
endinterface

interface ldfs_csr_if;
   logic                           valid;
   logic                           ready;
   logic [ldfs_pkg::CSR_IDX_W-1:0] index;
   logic [ldfs_pkg::GREY_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/ldfs_ram.sv
module ldfs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/core/ldfs_csr.sv
module ldfs_csr (
   input  logic                          clock,
   input  logic                          reset,
   ldfs_csr_if.sink                      csr_chan,
   output logic [ldfs_pkg::GREY_W-1:0]   command_word,
   output logic [ldfs_pkg::CHAIN_W-1:0]  chain_length,
   output logic [ldfs_pkg::WAIT_W-1:0]   latch_wait_ticks
);

   logic [ldfs_pkg::GREY_W-1:0]  command_ff;
   logic [ldfs_pkg::CHAIN_W-1:0] chain_ff;
   logic [ldfs_pkg::WAIT_W-1:0]  wait_ff;
   logic                         wr;

   assign csr_chan.ready = 1'b1;
   assign wr = csr_chan.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         command_ff <= '0;
         chain_ff   <= ldfs_pkg::CHAIN_W'(1);
         wait_ff    <= ldfs_pkg::WAIT_RESET;
      end else if (wr) begin
         case (csr_chan.index)
            ldfs_pkg::CSR_COMMAND: command_ff <= csr_chan.data;
            ldfs_pkg::CSR_CHAIN:   chain_ff   <= csr_chan.data[ldfs_pkg::CHAIN_W-1:0];
            ldfs_pkg::CSR_WAIT:    wait_ff    <= csr_chan.data[ldfs_pkg::WAIT_W-1:0];
            default: ;  // unmapped index, dropped
         endcase
      end
   end

   assign command_word     = command_ff;
   assign chain_length     = chain_ff;
   assign latch_wait_ticks = wait_ff;

endmodule

FILE: rtl/core/ldfs_ctrl.sv
module ldfs_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_mode,
   input  logic [ldfs_pkg::CHAN_W-1:0]   req_channel,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [ldfs_pkg::CHAIN_W-1:0]  chain_length,
   input  logic [ldfs_pkg::WAIT_W-1:0]   latch_wait_ticks,
   output ldfs_pkg::ldfs_cmd_type        cmd
);

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_SHIFT = 2'd1,
      PH_WAIT  = 2'd2,
      PH_LATCH = 2'd3
   } phase_type;

   phase_type                     phase_ff, phase_in;
   logic [ldfs_pkg::CHIP_W-1:0]   chip_ff, chip_in;
   logic [ldfs_pkg::WORD_W-1:0]   word_ff, word_in;
   logic [ldfs_pkg::WORD_W-1:0]   bit_ff, bit_in;
   logic [ldfs_pkg::WAIT_W-1:0]   wait_ff, wait_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic                          accept;
   ldfs_pkg::mode_type            mode;
   logic [ldfs_pkg::CHIP_CW-1:0]  active;
   logic [ldfs_pkg::CHIP_CW-1:0]  chip_next;
   logic [ldfs_pkg::WORD_W-1:0]   bit_inc;
   logic [ldfs_pkg::WAIT_W-1:0]   wait_inc;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign mode      = ldfs_pkg::mode_type'(req_mode);
   assign rsp_valid = rsp_valid_ff;

   // chain length clamped to 1..MAX_CHIPS
   always_comb begin
      if (chain_length == '0) begin
         active = ldfs_pkg::CHIP_CW'(1);
      end else if (int'(chain_length) > ldfs_pkg::MAX_CHIPS) begin
         active = ldfs_pkg::CHIP_CW'(ldfs_pkg::MAX_CHIPS);
      end else begin
         active = ldfs_pkg::CHIP_CW'(chain_length);
      end
   end

   assign chip_next = {1'b0, chip_ff} + ldfs_pkg::CHIP_CW'(1);
   assign bit_inc   = bit_ff + ldfs_pkg::WORD_W'(1);
   assign wait_inc  = wait_ff + ldfs_pkg::WAIT_W'(1);

   always_comb begin
      phase_in     = phase_ff;
      chip_in      = chip_ff;
      word_in      = word_ff;
      bit_in       = bit_ff;
      wait_in      = wait_ff;
      rsp_valid_in = rsp_valid_ff;

      cmd                = '0;
      cmd.accept         = accept;
      cmd.rd_chip        = chip_ff;
      cmd.rd_word        = word_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         rsp_valid_in = 1'b1;
         case (mode)
            ldfs_pkg::MODE_RAW, ldfs_pkg::MODE_SCALED: begin
               cmd.store_we = (phase_ff == PH_IDLE) &&
                              (int'(req_channel) < ldfs_pkg::CH_PER_CHIP);
            end
            ldfs_pkg::MODE_REFRESH: begin
               if (phase_ff == PH_IDLE) begin
                  phase_in     = PH_SHIFT;
                  chip_in      = '0;
                  word_in      = '0;
                  bit_in       = '0;
                  cmd.load_cmd = 1'b1;
               end
            end
            default: begin  // tick
               cmd.pin_we = 1'b1;
               case (phase_ff)
                  PH_SHIFT: begin
                     cmd.pin_from_shift = 1'b1;
                     cmd.pin_clock      = !bit_ff[0];
                     cmd.shift_en       = 1'b1;
                     bit_in             = bit_inc;
                     if (bit_ff == '1) begin
                        bit_in = '0;
                        if (int'(word_ff) == ldfs_pkg::WORDS_PER_CHIP - 1) begin
                           word_in = '0;
                           if (chip_next >= active) begin
                              // last chip done: wait if a latch wait is set, then latch
                              chip_in  = '0;
                              wait_in  = '0;
                              phase_in = (latch_wait_ticks == '0) ? PH_LATCH : PH_WAIT;
                           end else begin
                              chip_in      = chip_next[ldfs_pkg::CHIP_W-1:0];
                              cmd.load_cmd = 1'b1;
                           end
                        end else begin
                           word_in      = word_ff + ldfs_pkg::WORD_W'(1);
                           cmd.load_mem = 1'b1;
                        end
                     end
                  end
                  PH_WAIT: begin
                     wait_in = wait_inc;
                     if (wait_inc == '0 || wait_inc >= latch_wait_ticks) begin
                        wait_in  = '0;
                        bit_in   = '0;
                        phase_in = PH_LATCH;
                     end
                  end
                  PH_LATCH: begin
                     cmd.pin_data = !bit_ff[0];
                     bit_in       = bit_inc;
                     if (bit_inc >= ldfs_pkg::LATCH_BITS) begin
                        bit_in   = '0;
                        phase_in = PH_IDLE;
                     end
                  end
                  default: ;  // idle tick drives both lines low
               endcase
            end
         endcase
      end

      cmd.busy = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         chip_ff      <= '0;
         word_ff      <= '0;
         bit_ff       <= '0;
         wait_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         chip_ff      <= chip_in;
         word_ff      <= word_in;
         bit_ff       <= bit_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/core/ldfs_datapath.sv
module ldfs_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  ldfs_pkg::ldfs_cmd_type          cmd,
   input  logic [ldfs_pkg::CHIP_NUM_W-1:0] req_chip_number,
   input  logic [ldfs_pkg::CHAN_W-1:0]     req_channel,
   input  logic [ldfs_pkg::GREY_W-1:0]     req_raw_value,
   input  logic [ldfs_pkg::FRAC_W-1:0]     req_fraction,
   input  logic [1:0]                      req_mode,
   input  logic [ldfs_pkg::GREY_W-1:0]     command_word,
   output logic                            data_pin,
   output logic                            clock_pin,
   output logic                            busy_res
);

   logic [ldfs_pkg::CHIP_W-1:0]   chip_sel;
   logic [ldfs_pkg::STORE_AW-1:0] waddr;
   logic [ldfs_pkg::STORE_AW-1:0] raddr;
   logic [ldfs_pkg::GREY_W-1:0]   wdata;
   logic [ldfs_pkg::GREY_W-1:0]   rdata;
   logic [ldfs_pkg::FRAC_W-1:0]   frac_clamp;
   logic [ldfs_pkg::PROD_W-1:0]   product;

   logic [ldfs_pkg::STORE_DEPTH-1:0] valid_ff;
   logic                             rd_valid_ff;
   logic [ldfs_pkg::GREY_W-1:0]      shift_ff;
   logic                             pin_data_ff;
   logic                             pin_clock_ff;
   logic                             busy_ff;

   // chip 0 or past MAX_CHIPS falls back to chip 1
   always_comb begin
      if (req_chip_number == '0 || int'(req_chip_number) > ldfs_pkg::MAX_CHIPS) begin
         chip_sel = '0;
      end else begin
         chip_sel = ldfs_pkg::CHIP_W'(req_chip_number - ldfs_pkg::CHIP_NUM_W'(1));
      end
   end

   assign waddr = ldfs_pkg::STORE_AW'(chip_sel) *
                  ldfs_pkg::STORE_AW'(ldfs_pkg::CH_PER_CHIP) +
                  ldfs_pkg::STORE_AW'(req_channel);
   assign raddr = ldfs_pkg::STORE_AW'(cmd.rd_chip) *
                  ldfs_pkg::STORE_AW'(ldfs_pkg::CH_PER_CHIP) +
                  ldfs_pkg::STORE_AW'(ldfs_pkg::send_order(cmd.rd_word));

   // scaled word: floor(fraction * bias / 2^16), fraction clamped to full
   assign frac_clamp = (req_fraction > ldfs_pkg::FRAC_FULL) ? ldfs_pkg::FRAC_FULL
                                                            : req_fraction;
   assign product = ldfs_pkg::PROD_W'(frac_clamp) *
                    ldfs_pkg::PROD_W'(ldfs_pkg::grey_bias(command_word[9:8]));
   assign wdata = (ldfs_pkg::mode_type'(req_mode) == ldfs_pkg::MODE_SCALED)
                  ? product[ldfs_pkg::GREY_W+15:16] : req_raw_value;

   ldfs_ram #(
      .WIDTH (ldfs_pkg::GREY_W),
      .DEPTH (ldfs_pkg::STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (cmd.store_we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   // per-entry written flags; unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.store_we) begin
            valid_ff[waddr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= '0;
         pin_data_ff  <= 1'b0;
         pin_clock_ff <= 1'b0;
         busy_ff      <= 1'b0;
      end else begin
         if (cmd.load_cmd) begin
            shift_ff <= command_word;
         end else if (cmd.load_mem) begin
            shift_ff <= rd_valid_ff ? rdata : '0;
         end else if (cmd.shift_en) begin
            shift_ff <= {shift_ff[ldfs_pkg::GREY_W-2:0], 1'b0};
         end
         if (cmd.pin_we) begin
            pin_data_ff  <= cmd.pin_from_shift ? shift_ff[ldfs_pkg::GREY_W-1] : cmd.pin_data;
            pin_clock_ff <= cmd.pin_clock;
         end
         if (cmd.accept) begin
            busy_ff <= cmd.busy;
         end
      end
   end

   assign data_pin  = pin_data_ff;
   assign clock_pin = pin_clock_ff;
   assign busy_res  = busy_ff;

endmodule

FILE: rtl/core/led_driver_frame_shift_out_unit.sv
// Frame shifter for a chain of serial grey-scale LED driver chips.
//
// req_chan takes one word per item: mode 0 stores a raw grey word, mode 1
// stores fraction times the grey-depth bias, mode 2 starts a refresh and
// mode 3 is a time tick that advances the serial line by one half clock.
// Stores and refresh requests are dropped while a refresh is running.
// rsp_chan returns exactly one word per item: data and clock pin levels plus
// the busy flag, all as they stand after that item.
// csr_chan writes command word, chain length and latch wait; write only
// while no item is in flight.
//
// Timing: a response appears in the cycle after its item is accepted; one item
// per cycle is sustained as long as rsp_chan keeps taking words. The single
// response register is the only buffer: while it is held, req_chan.ready
// drops, except in the cycle the held word is taken.
// Reset clears the pins, the sequencer and the frame-store written flags, so
// the store reads as all zero at once; no clearing pass.

module led_driver_frame_shift_out_unit (
   input  logic        clock,
   input  logic        reset,
   ldfs_req_if.sink    req_chan,
   ldfs_rsp_if.source  rsp_chan,
   ldfs_csr_if.sink    csr_chan
);

   logic [ldfs_pkg::GREY_W-1:0]  command_word;
   logic [ldfs_pkg::CHAIN_W-1:0] chain_length;
   logic [ldfs_pkg::WAIT_W-1:0]  latch_wait_ticks;
   ldfs_pkg::ldfs_cmd_type       cmd;

   // register file, always ready
   ldfs_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_chan         (csr_chan),
      .command_word     (command_word),
      .chain_length     (chain_length),
      .latch_wait_ticks (latch_wait_ticks)
   );

   // phase sequencer and handshake; counters for chip, word, bit and wait
   ldfs_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_ready        (req_chan.ready),
      .req_mode         (req_chan.mode),
      .req_channel      (req_chan.channel),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .chain_length     (chain_length),
      .latch_wait_ticks (latch_wait_ticks),
      .cmd              (cmd)
   );

   // frame store, scaler, shift register and pin/response registers.
   // The next word of a chip is read continuously from the sequencer's
   // counters, so it is ready long before the last bit of the current one.
   ldfs_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_chip_number (req_chan.chip_number),
      .req_channel     (req_chan.channel),
      .req_raw_value   (req_chan.raw_value),
      .req_fraction    (req_chan.fraction),
      .req_mode        (req_chan.mode),
      .command_word    (command_word),
      .data_pin        (rsp_chan.data_pin),
      .clock_pin       (rsp_chan.clock_pin),
      .busy_res        (rsp_chan.busy_res)
   );

endmodule
